// File: src/itc_pkg.sv
package itc_pkg;

    localparam int FRAC_BITS = 16;

    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int M_W       = 32;
    localparam int P_W       = 31;
    localparam int T_W       = 48;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIME_DIAL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT_P = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Q   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_K1  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_K2  = 3'd6;

    localparam logic [CFG_W-1:0] RST_TIME_DIAL  = CFG_W'(64'd39 << FRAC_BITS);
    localparam logic [CFG_W-1:0] RST_COEF_A     = CFG_W'(64'd1 << FRAC_BITS);
    localparam logic [CFG_W-1:0] RST_COEF_B     = '0;
    localparam logic [P_W-1:0]   RST_EXPONENT_P = P_W'(64'd2 << FRAC_BITS);
    localparam logic [CFG_W-1:0] RST_OFFSET_Q   =
        CFG_W'(((64'd11025 << FRAC_BITS) + 64'd5000) / 64'd10000);
    localparam logic [CFG_W-1:0] RST_OFFSET_K1  = '0;
    localparam logic [CFG_W-1:0] RST_OFFSET_K2  = '0;

    // fixed-point widths
    localparam int Q30_W  = 31;               // Q30 mantissa in [1,2)
    localparam int IP_W   = 6;                // integer part of log2
    localparam int LOG_W  = IP_W + FRAC_BITS;
    localparam int EP_W   = P_W + 1 + LOG_W;  // P * log2 M
    localparam int N_W    = EP_W - 2 * FRAC_BITS;
    localparam int POW_W  = 63;               // M^P, capped at 2^62
    localparam int MR_W   = 64 - FRAC_BITS;   // rounded 32x32 product
    localparam int NUM_W  = MR_W + 1;
    localparam int UD_W   = 63;               // |M^P - Q|
    localparam int QB     = 61;               // quotient bits, 2^60 cap plus round bit
    localparam int DVD_W  = NUM_W + FRAC_BITS + 1;
    localparam int CAP_SH = 60 - FRAC_BITS;
    localparam int CMP_W  = UD_W + CAP_SH;

    localparam logic [POW_W-1:0] POW_CAP = POW_W'(64'd1 << 62);

    typedef struct packed {
        logic vld;
        logic neg;
        logic sing;
        logic cap;
    } t_div_side;

    typedef logic [FRAC_BITS:1][Q30_W-1:0] t_root_tab;

    // 2^(2^-k) in Q30 by repeated floor square roots from 2.0
    function automatic t_root_tab calc_roots();
        t_root_tab   tab;
        logic [63:0] r;
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bt;
        r = 64'd1 << 31;
        for (int k = 1; k <= FRAC_BITS; k++) begin
            v   = r << 30;
            res = '0;
            bt  = 64'd1 << 62;
            for (int j = 0; j < 32; j++) begin
                if (bt > v) bt = bt >> 2;
            end
            for (int j = 0; j < 32; j++) begin
                if (bt != 0) begin
                    if (v >= res + bt) begin
                        v   = v - (res + bt);
                        res = (res >> 1) + bt;
                    end else begin
                        res = res >> 1;
                    end
                    bt = bt >> 2;
                end
            end
            r      = res;
            tab[k] = Q30_W'(res);
        end
        return tab;
    endfunction

    localparam t_root_tab ROOTS = calc_roots();

endpackage

// File: src/itc_pow.sv
module itc_pow (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  logic [itc_pkg::M_W-1:0]    i_m,
    input  logic [itc_pkg::P_W-1:0]    i_p,
    output logic                       o_vld,
    output logic [itc_pkg::POW_W-1:0]  o_pow
);
    import itc_pkg::*;

    localparam logic [Q30_W-1:0] ACC_ONE = Q30_W'(64'd1 << 30);

    // normalize stage
    logic                    r_a_v;
    logic [Q30_W-1:0]        r_a_x;
    logic signed [IP_W-1:0]  r_a_ip;
    logic                    r_a_mz;
    logic [4:0]              n_msb;
    logic [62:0]             n_w;

    // log2 squaring stages
    logic                    r_l_v  [FRAC_BITS];
    logic [Q30_W-1:0]        r_l_x  [FRAC_BITS];
    logic [FRAC_BITS-1:0]    r_l_fr [FRAC_BITS];
    logic signed [IP_W-1:0]  r_l_ip [FRAC_BITS];
    logic                    r_l_mz [FRAC_BITS];
    logic [Q30_W-1:0]        n_l_x  [FRAC_BITS];
    logic [FRAC_BITS-1:0]    n_l_fr [FRAC_BITS];

    // exponent product stage
    logic                    r_e_v;
    logic signed [N_W-1:0]   r_e_n;
    logic [FRAC_BITS-1:0]    r_e_f;
    logic                    r_e_mz;
    logic signed [LOG_W-1:0] n_log;
    logic signed [EP_W-1:0]  n_prod;

    // exp2 product stages
    logic                    r_x_v   [FRAC_BITS];
    logic [Q30_W-1:0]        r_x_acc [FRAC_BITS];
    logic [FRAC_BITS-1:0]    r_x_f   [FRAC_BITS];
    logic signed [N_W-1:0]   r_x_n   [FRAC_BITS];
    logic                    r_x_mz  [FRAC_BITS];
    logic [Q30_W-1:0]        n_x_acc [FRAC_BITS];

    // scale stage
    logic                    r_s_v;
    logic [POW_W-1:0]        r_pow;
    logic [POW_W-1:0]        n_pow;
    logic signed [N_W:0]     n_s;

    always_comb begin
        n_msb = '0;
        for (int i = 0; i < M_W; i++) begin
            if (i_m[i]) n_msb = 5'(i);
        end
        // msb lands on bit 62, truncating when it was already bit 31
        n_w = {31'b0, i_m} << (6'd62 - 6'(n_msb));
    end

    always_comb begin
        logic [Q30_W-1:0]     sx;
        logic [FRAC_BITS-1:0] sfr;
        logic [61:0]          sq;
        for (int j = 0; j < FRAC_BITS; j++) begin
            sx  = (j == 0) ? r_a_x : r_l_x[(j == 0) ? 0 : j - 1];
            sfr = (j == 0) ? '0 : r_l_fr[(j == 0) ? 0 : j - 1];
            sq  = 62'(sx) * 62'(sx);
            if (sq[61]) begin
                n_l_x[j]  = sq[61:31];
                n_l_fr[j] = sfr | (FRAC_BITS'(1) << (FRAC_BITS - 1 - j));
            end else begin
                n_l_x[j]  = sq[60:30];
                n_l_fr[j] = sfr;
            end
        end
    end

    always_comb begin
        n_log  = $signed({r_l_ip[FRAC_BITS-1], r_l_fr[FRAC_BITS-1]});
        n_prod = $signed(EP_W'({1'b0, i_p})) * EP_W'(n_log)
               + EP_W'(64'd1 << (FRAC_BITS - 1));
    end

    always_comb begin
        logic [Q30_W-1:0]     sacc;
        logic [FRAC_BITS-1:0] sf;
        logic [61:0]          pr;
        for (int j = 0; j < FRAC_BITS; j++) begin
            sacc = (j == 0) ? ACC_ONE : r_x_acc[(j == 0) ? 0 : j - 1];
            sf   = (j == 0) ? r_e_f : r_x_f[(j == 0) ? 0 : j - 1];
            pr   = 62'(sacc) * 62'(ROOTS[j+1]) + 62'(64'd1 << 29);
            n_x_acc[j] = sf[FRAC_BITS-1-j] ? pr[60:30] : sacc;
        end
    end

    always_comb begin
        logic [63:0] v;
        logic [5:0]  sh;
        n_s   = (N_W+1)'(r_x_n[FRAC_BITS-1]) + (N_W+1)'(FRAC_BITS - 30);
        v     = '0;
        sh    = '0;
        n_pow = '0;
        if (r_x_mz[FRAC_BITS-1]) begin
            n_pow = '0;
        end else if (!n_s[N_W]) begin
            if (n_s > (N_W+1)'(31)) begin
                n_pow = POW_CAP;
            end else begin
                v     = 64'(r_x_acc[FRAC_BITS-1]) << n_s[4:0];
                n_pow = (v > 64'(POW_CAP)) ? POW_CAP : v[POW_W-1:0];
            end
        end else if (n_s < -(N_W+1)'(62)) begin
            n_pow = '0;
        end else begin
            sh    = 6'(-n_s);
            v     = (64'(r_x_acc[FRAC_BITS-1]) + (64'd1 << (sh - 6'd1))) >> sh;
            n_pow = v[POW_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_x  <= n_w[62:32];
            r_a_ip <= $signed({1'b0, n_msb}) - IP_W'(FRAC_BITS);
            r_a_mz <= (i_m == '0);
            for (int j = 0; j < FRAC_BITS; j++) begin
                r_l_x[j]  <= n_l_x[j];
                r_l_fr[j] <= n_l_fr[j];
                r_l_ip[j] <= (j == 0) ? r_a_ip : r_l_ip[(j == 0) ? 0 : j - 1];
                r_l_mz[j] <= (j == 0) ? r_a_mz : r_l_mz[(j == 0) ? 0 : j - 1];
            end
            r_e_n  <= N_W'(n_prod >>> (2 * FRAC_BITS));
            r_e_f  <= n_prod[2*FRAC_BITS-1:FRAC_BITS];
            r_e_mz <= r_l_mz[FRAC_BITS-1];
            for (int j = 0; j < FRAC_BITS; j++) begin
                r_x_acc[j] <= n_x_acc[j];
                r_x_f[j]   <= (j == 0) ? r_e_f  : r_x_f[(j == 0) ? 0 : j - 1];
                r_x_n[j]   <= (j == 0) ? r_e_n  : r_x_n[(j == 0) ? 0 : j - 1];
                r_x_mz[j]  <= (j == 0) ? r_e_mz : r_x_mz[(j == 0) ? 0 : j - 1];
            end
            r_pow <= n_pow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_e_v <= 1'b0;
            r_s_v <= 1'b0;
            for (int j = 0; j < FRAC_BITS; j++) begin
                r_l_v[j] <= 1'b0;
                r_x_v[j] <= 1'b0;
            end
        end else if (i_en) begin
            r_a_v <= i_vld;
            for (int j = 0; j < FRAC_BITS; j++) begin
                r_l_v[j] <= (j == 0) ? r_a_v : r_l_v[(j == 0) ? 0 : j - 1];
                r_x_v[j] <= (j == 0) ? r_e_v : r_x_v[(j == 0) ? 0 : j - 1];
            end
            r_e_v <= r_l_v[FRAC_BITS-1];
            r_s_v <= r_x_v[FRAC_BITS-1];
        end
    end

    assign o_vld = r_s_v;
    assign o_pow = r_pow;

endmodule

// File: src/itc_div.sv
module itc_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  itc_pkg::t_div_side        i_side,
    input  logic [itc_pkg::UD_W-1:0]  i_rem,
    input  logic [itc_pkg::QB-1:0]    i_dq,
    input  logic [itc_pkg::UD_W-1:0]  i_ud,
    output itc_pkg::t_div_side        o_side,
    output logic [itc_pkg::QB-1:0]    o_quo
);
    import itc_pkg::*;

    // restoring divider, one quotient bit per stage; dq shifts dividend
    // bits out at the top and quotient bits in at the bottom
    t_div_side         r_side [QB];
    logic [UD_W-1:0]   r_rem  [QB];
    logic [QB-1:0]     r_dq   [QB];
    logic [UD_W-1:0]   r_ud   [QB];
    logic [UD_W-1:0]   n_rem  [QB];
    logic [QB-1:0]     n_dq   [QB];

    always_comb begin
        logic [UD_W-1:0] srem;
        logic [QB-1:0]   sdq;
        logic [UD_W-1:0] sud;
        logic [UD_W:0]   t;
        logic            ge;
        for (int j = 0; j < QB; j++) begin
            srem = (j == 0) ? i_rem : r_rem[(j == 0) ? 0 : j - 1];
            sdq  = (j == 0) ? i_dq  : r_dq[(j == 0) ? 0 : j - 1];
            sud  = (j == 0) ? i_ud  : r_ud[(j == 0) ? 0 : j - 1];
            t    = {srem, sdq[QB-1]};
            ge   = (t >= {1'b0, sud});
            n_rem[j] = ge ? UD_W'(t - {1'b0, sud}) : t[UD_W-1:0];
            n_dq[j]  = {sdq[QB-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < QB; j++) begin
                r_rem[j] <= n_rem[j];
                r_dq[j]  <= n_dq[j];
                r_ud[j]  <= (j == 0) ? i_ud : r_ud[(j == 0) ? 0 : j - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < QB; j++) r_side[j] <= '0;
        end else if (i_en) begin
            for (int j = 0; j < QB; j++) begin
                r_side[j] <= (j == 0) ? i_side : r_side[(j == 0) ? 0 : j - 1];
            end
        end
    end

    assign o_side = r_side[QB-1];
    assign o_quo  = r_dq[QB-1];

endmodule

// File: src/inverse_time_trip_calculator.sv
// channel   signals                                   direction
// in        i_in_valid / o_in_ready, i_current_multiple  word in
// out       o_out_valid / i_out_ready, o_trip_time,
//           o_singular, o_saturated                   word out
// cfg       i_cfg_valid / o_cfg_ready, i_cfg_index,
//           i_cfg_data                                register write
//
// One word per cycle while the output is not stalled; the pipeline holds 16 log2
// squaring stages, 16 exp2 product stages and a 61-stage restoring divider.
// Synchronous active-low reset clears valid bits and loads register defaults.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// Config writes are always taken (o_cfg_ready is high).
module inverse_time_trip_calculator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [itc_pkg::M_W-1:0]           i_current_multiple,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [itc_pkg::T_W-1:0]    o_trip_time,
    output logic                              o_singular,
    output logic                              o_saturated,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [itc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [itc_pkg::CFG_W-1:0]         i_cfg_data
);
    import itc_pkg::*;

    localparam logic signed [63:0] T_MAX = (64'sd1 <<< (T_W - 1)) - 64'sd1;
    localparam logic signed [63:0] T_MIN = -(64'sd1 <<< (T_W - 1));

    logic en;

    // configuration
    logic signed [CFG_W-1:0] r_time_dial, r_coef_a, r_coef_b;
    logic signed [CFG_W-1:0] r_offset_q, r_offset_k1, r_offset_k2;
    logic [P_W-1:0]          r_exponent_p;

    // curve numerator and additive term, refreshed from config every cycle
    logic signed [63:0]      r_pa, r_pb;
    logic signed [NUM_W-1:0] r_num, r_rest;
    logic [NUM_W-1:0]        r_un;

    logic                    pow_vld;
    logic [POW_W-1:0]        pow;

    // denominator stage
    logic                    r_d_v, r_d_neg, r_d_sing;
    logic [UD_W-1:0]         r_d_ud;
    logic signed [63:0]      n_d;

    // divider setup stage
    logic                    r_c_vld, r_c_neg, r_c_sing, r_c_cap;
    t_div_side               c_side;
    logic [UD_W-1:0]         r_c_rem, r_c_ud;
    logic [QB-1:0]           r_c_dq;
    logic [DVD_W-1:0]        n_dvd;

    t_div_side               div_side;
    logic [QB-1:0]           div_quo;

    // output stage
    logic                    r_f_v, r_f_sing, r_f_sat;
    logic signed [T_W-1:0]   r_f_t;
    logic [QB-1:0]           n_mag;
    logic signed [QB:0]      n_quo;
    logic signed [63:0]      n_t;

    assign en          = !r_f_v || i_out_ready;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_dial  <= RST_TIME_DIAL;
            r_coef_a     <= RST_COEF_A;
            r_coef_b     <= RST_COEF_B;
            r_exponent_p <= RST_EXPONENT_P;
            r_offset_q   <= RST_OFFSET_Q;
            r_offset_k1  <= RST_OFFSET_K1;
            r_offset_k2  <= RST_OFFSET_K2;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TIME_DIAL:  r_time_dial  <= i_cfg_data;
                REG_COEF_A:     r_coef_a     <= i_cfg_data;
                REG_COEF_B:     r_coef_b     <= i_cfg_data;
                REG_EXPONENT_P: r_exponent_p <= i_cfg_data[P_W-1:0];
                REG_OFFSET_Q:   r_offset_q   <= i_cfg_data;
                REG_OFFSET_K1:  r_offset_k1  <= i_cfg_data;
                REG_OFFSET_K2:  r_offset_k2  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_pa   <= 64'(r_coef_a) * 64'(r_time_dial);
        r_pb   <= 64'(r_coef_b) * 64'(r_time_dial);
        r_num  <= NUM_W'((r_pa + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS)
                + NUM_W'(r_offset_k1);
        r_rest <= NUM_W'((r_pb + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS)
                + NUM_W'(r_offset_k2);
        r_un   <= r_num[NUM_W-1] ? NUM_W'(-r_num) : NUM_W'(r_num);
    end

    itc_pow u_pow (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_in_valid),
        .i_m     (i_current_multiple),
        .i_p     (r_exponent_p),
        .o_vld   (pow_vld),
        .o_pow   (pow)
    );

    assign n_d = $signed({1'b0, pow}) - 64'(r_offset_q);

    // dividend is |num| scaled for FRAC_BITS quotient bits plus a round bit
    assign n_dvd = {r_un, {(FRAC_BITS + 1){1'b0}}};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_sing <= (n_d == 64'sd0);
            r_d_neg  <= r_num[NUM_W-1] ^ n_d[63];
            r_d_ud   <= n_d[63] ? UD_W'(-n_d) : UD_W'(n_d);

            r_c_neg  <= r_d_neg;
            r_c_sing <= r_d_sing;
            r_c_cap  <= (CMP_W'(r_un) >= (CMP_W'(r_d_ud) << CAP_SH));
            r_c_rem  <= UD_W'(n_dvd >> QB);
            r_c_dq   <= n_dvd[QB-1:0];
            r_c_ud   <= r_d_ud;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v   <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_d_v   <= pow_vld;
            r_c_vld <= r_d_v;
        end
    end

    assign c_side = '{vld: r_c_vld, neg: r_c_neg, sing: r_c_sing, cap: r_c_cap};

    itc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_side  (c_side),
        .i_rem   (r_c_rem),
        .i_dq    (r_c_dq),
        .i_ud    (r_c_ud),
        .o_side  (div_side),
        .o_quo   (div_quo)
    );

    always_comb begin
        n_mag = div_side.cap ? (QB'(1) << (QB - 1))
                             : (div_quo >> 1) + QB'(div_quo[0]);
        n_quo = div_side.neg ? -$signed({1'b0, n_mag}) : $signed({1'b0, n_mag});
        n_t   = 64'(n_quo) + 64'(r_rest);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (div_side.sing) begin
                r_f_t    <= -(T_W'(64'd1 << FRAC_BITS));
                r_f_sing <= 1'b1;
                r_f_sat  <= 1'b0;
            end else if (n_t > T_MAX) begin
                r_f_t    <= T_W'(T_MAX);
                r_f_sing <= 1'b0;
                r_f_sat  <= 1'b1;
            end else if (n_t < T_MIN) begin
                r_f_t    <= T_W'(T_MIN);
                r_f_sing <= 1'b0;
                r_f_sat  <= 1'b1;
            end else begin
                r_f_t    <= T_W'(n_t);
                r_f_sing <= 1'b0;
                r_f_sat  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (en) begin
            r_f_v <= div_side.vld;
        end
    end

    assign o_out_valid = r_f_v;
    assign o_trip_time = r_f_t;
    assign o_singular  = r_f_sing;
    assign o_saturated = r_f_sat;

endmodule

// File: src/itc_chk.sv
module itc_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_in_ready,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic signed [itc_pkg::T_W-1:0]    o_trip_time,
    input logic                              o_singular,
    input logic                              o_saturated
);

    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_trip_time))
        else $error("stalled output word changed");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without output stall");

    a_singular: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_singular |->
            !o_saturated && o_trip_time == -(48'sd1 <<< itc_pkg::FRAC_BITS))
        else $error("singular word not -1.0");

    a_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |->
            o_trip_time == 48'sh7FFF_FFFF_FFFF || o_trip_time == 48'sh8000_0000_0000)
        else $error("saturated word not at range limit");

endmodule

bind inverse_time_trip_calculator itc_chk u_itc_chk (.*);

// File: dv/tb_inverse_time_trip_calculator.sv
module tb_inverse_time_trip_calculator;
    timeunit 1ns;
    timeprecision 1ps;

    import itc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int DRAIN_CYCLES = 120;   // pipeline is 99 deep
    localparam int STALL_LIMIT  = 5000;
    localparam int LONG_HOLD    = 500;

    typedef struct packed {
        logic [T_W-1:0] trip;
        logic           sing;
        logic           sat;
    } t_trip_word;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [M_W-1:0]       i_current_multiple;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic signed [T_W-1:0] o_trip_time;
    logic                 o_singular;
    logic                 o_saturated;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    inverse_time_trip_calculator dut (.*);

    // curve settings as the block should hold them
    logic [CFG_W-1:0] tp_r, a_r, b_r, q_r, k1_r, k2_r;
    logic [P_W-1:0]   p_r;

    logic [M_W-1:0] pending_m[$];
    t_trip_word     trip_expect[$];
    int             errors;
    int             words_out;
    int             idle_cycles;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic longint sx32(logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned res;
        longint unsigned bt;
        res = 0;
        bt  = 64'd1 << 62;
        while (bt > v) bt = bt >> 2;
        while (bt != 0) begin
            if (v >= res + bt) begin
                v   = v - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    function automatic longint log2_of(logic [31:0] m);
        int              b;
        longint unsigned x;
        longint          fr;
        b  = 31;
        fr = 0;
        while (m[b] == 1'b0) b--;
        x = (b <= 30) ? (64'(m) << (30 - b)) : (64'(m) >> 1);
        for (int i = 1; i <= FRAC_BITS; i++) begin
            x = (x * x) >> 30;
            if (x >= (64'd1 << 31)) begin
                fr = fr | (64'd1 << (FRAC_BITS - i));
                x  = x >> 1;
            end
        end
        return longint'(b - FRAC_BITS) * (64'sd1 << FRAC_BITS) + fr;
    endfunction

    function automatic longint unsigned power_of(logic [31:0] m, logic [P_W-1:0] p);
        longint          e, n, s;
        longint unsigned f, acc, r, v;
        if (m == 0) return 0;
        e   = (longint'(p) * log2_of(m) + (64'sd1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
        n   = e >>> FRAC_BITS;
        f   = e - (n <<< FRAC_BITS);
        acc = 64'd1 << 30;
        r   = 64'd1 << 31;
        for (int k = 1; k <= FRAC_BITS; k++) begin
            r = floor_root(r << 30);
            if (f[FRAC_BITS - k]) acc = (acc * r + (64'd1 << 29)) >> 30;
        end
        s = n + FRAC_BITS - 30;
        if (s >= 0) begin
            if (s > 31) return 64'd1 << 62;
            v = acc << s;
            return (v > (64'd1 << 62)) ? (64'd1 << 62) : v;
        end
        if (s < -62) return 0;
        s = -s;
        return (acc + (64'd1 << (s - 1))) >> s;
    endfunction

    function automatic longint scaled_product(logic [31:0] x, logic [31:0] y);
        return (sx32(x) * sx32(y) + (64'sd1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic t_trip_word operate_time(logic [M_W-1:0] m);
        t_trip_word      w;
        longint          d, num, rest, quo, t;
        longint unsigned un, ud, q1, rm, mag;
        logic            neg;
        w = '0;
        d = longint'(power_of(m, p_r)) - sx32(q_r);
        if (d == 0) begin
            w.trip = T_W'(-(64'sd1 << FRAC_BITS));
            w.sing = 1'b1;
            return w;
        end
        num  = scaled_product(a_r, tp_r) + sx32(k1_r);
        rest = scaled_product(b_r, tp_r) + sx32(k2_r);
        neg  = (num < 0) != (d < 0);
        un   = (num < 0) ? -num : num;
        ud   = (d < 0) ? -d : d;
        q1   = un / ud;
        rm   = un % ud;
        if (q1 >= (64'd1 << (60 - FRAC_BITS))) begin
            mag = 64'd1 << 60;
        end else begin
            mag = q1;
            for (int i = 0; i < FRAC_BITS; i++) begin
                rm  = rm << 1;
                mag = mag << 1;
                if (rm >= ud) begin
                    rm  = rm - ud;
                    mag = mag | 1;
                end
            end
            rm = rm << 1;
            if (rm >= ud) mag++;
        end
        quo = neg ? -longint'(mag) : longint'(mag);
        t   = quo + rest;
        if (t > (64'sd1 <<< 47) - 1) begin
            t     = (64'sd1 <<< 47) - 1;
            w.sat = 1'b1;
        end
        if (t < -(64'sd1 <<< 47)) begin
            t     = -(64'sd1 <<< 47);
            w.sat = 1'b1;
        end
        w.trip = T_W'(t);
        return w;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch word %0d %s: got %h want %h", words_out, what, got, want);
        errors++;
    endtask

    // input side
    int in_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid         <= 1'b0;
            i_current_multiple <= '0;
            in_gap             <= 0;
        end else if (!(i_in_valid && !o_in_ready)) begin
            if (in_gap > 0) begin
                in_gap     <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (pending_m.size() > 0) begin
                i_in_valid         <= 1'b1;
                i_current_multiple <= pending_m.pop_front();
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: in_gap <= 0;
                    6, 7, 8:          in_gap <= $urandom_range(1, 3);
                    default:          in_gap <= $urandom_range(10, 40);
                endcase
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output side; one long hold-off so the pipeline backs up
    int  out_gap;
    logic long_done;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_gap     <= 0;
            long_done   <= 1'b0;
        end else if (!long_done && words_out >= 300) begin
            long_done   <= 1'b1;
            out_gap     <= LONG_HOLD;
            i_out_ready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap     <= out_gap - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            case ($urandom_range(0, 19))
                0, 1, 2: out_gap <= $urandom_range(1, 3);
                3:       out_gap <= $urandom_range(10, 40);
                default: out_gap <= 0;
            endcase
        end
    end

    // monitor and scoreboard
    always @(posedge i_clk) begin
        t_trip_word w;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) trip_expect.push_back(operate_time(i_current_multiple));
            if (o_out_valid && i_out_ready) begin
                if (trip_expect.size() == 0) begin
                    report_mismatch("unexpected word", 64'(o_trip_time), '0);
                end else begin
                    w = trip_expect.pop_front();
                    if (o_trip_time !== w.trip)
                        report_mismatch("trip_time", 64'(o_trip_time), 64'(w.trip));
                    if (o_singular !== w.sing)
                        report_mismatch("singular", 64'(o_singular), 64'(w.sing));
                    if (o_saturated !== w.sat)
                        report_mismatch("saturated", 64'(o_saturated), 64'(w.sat));
                end
                words_out++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // valid drops for one cycle after each write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        case (idx)
            REG_TIME_DIAL:  tp_r = val;
            REG_COEF_A:     a_r  = val;
            REG_COEF_B:     b_r  = val;
            REG_EXPONENT_P: p_r  = val[P_W-1:0];
            REG_OFFSET_Q:   q_r  = val;
            REG_OFFSET_K1:  k1_r = val;
            REG_OFFSET_K2:  k2_r = val;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_curve(logic [31:0] tp, logic [31:0] a, logic [31:0] b,
                              logic [31:0] p, logic [31:0] q, logic [31:0] k1,
                              logic [31:0] k2);
        write_reg(REG_TIME_DIAL, tp);
        write_reg(REG_COEF_A, a);
        write_reg(REG_COEF_B, b);
        write_reg(REG_EXPONENT_P, p);
        write_reg(REG_OFFSET_Q, q);
        write_reg(REG_OFFSET_K1, k1);
        write_reg(REG_OFFSET_K2, k2);
    endtask

    task automatic drain();
        while (pending_m.size() > 0 || i_in_valid || trip_expect.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_multiple();
        case ($urandom_range(0, 4))
            0:       return $urandom;
            1:       return $urandom >> $urandom_range(0, 31);
            2:       return 32'h10000 + $urandom_range(0, 8192) - 4096;
            3:       return $urandom_range(0, 20 << 16);
            default: return ($urandom_range(0, 50) == 0) ? 32'd0 : $urandom_range(1, 255);
        endcase
    endfunction

    task automatic queue_random(int count);
        repeat (count) pending_m.push_back(pick_multiple());
    endtask

    task automatic queue_directed();
        pending_m.push_back(32'd0);
        pending_m.push_back(32'd1);
        pending_m.push_back(32'hFFFF_FFFF);
        pending_m.push_back(32'h8000_0000);
        pending_m.push_back(32'h0001_0000);
        pending_m.push_back(32'h0000_8000);
        pending_m.push_back(32'h0001_0CCD);
        pending_m.push_back(32'h5555_5555);
        pending_m.push_back(32'hAAAA_AAAA);
    endtask

    initial begin
        errors      = 0;
        words_out   = 0;
        idle_cycles = 0;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_out_ready = 1'b0;
        i_current_multiple = '0;
        tp_r = RST_TIME_DIAL;
        a_r  = RST_COEF_A;
        b_r  = RST_COEF_B;
        p_r  = RST_EXPONENT_P;
        q_r  = RST_OFFSET_Q;
        k1_r = RST_OFFSET_K1;
        k2_r = RST_OFFSET_K2;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset curve, then plenty of traffic to exercise the long hold-off
        queue_directed();
        queue_random(400);
        drain();

        // Q = 1.0: M = 1.0 makes the denominator vanish; zero exponent too
        write_reg(REG_OFFSET_Q, 32'h0001_0000);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        pending_m.push_back(32'h0001_0000);
        drain();
        write_reg(REG_EXPONENT_P, 32'd0);
        queue_directed();
        drain();

        // extremes: curve settings at the ends of their ranges
        load_curve(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_directed();
        queue_random(40);
        drain();
        load_curve(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd0,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_directed();
        drain();

        // Q = 0 with a tiny denominator pushes the quotient into its cap
        load_curve(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'h0004_0000,
                   32'd0, 32'h7FFF_FFFF, 32'd0);
        queue_directed();
        queue_random(30);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            if (ph % 3 == 2)
                load_curve($urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom);
            else
                load_curve($urandom_range(1, 100 << 16), $urandom_range(0, 30 << 16),
                           $urandom_range(0, 1 << 16), $urandom_range(0, 6 << 16),
                           $urandom_range(0, 2 << 16), $urandom_range(0, 1 << 16),
                           $urandom_range(0, 1 << 16));
            queue_random(100);
            drain();
        end

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
